@@ src/nsc_pkg.sv @@
// ----------------------------------------------------------------------------
// NMEA sentence checker package
// Shared constants, result word type and a helper function.
// ----------------------------------------------------------------------------
package nsc_pkg;

    // Default line buffer size in bytes
    localparam int BUF_SIZE_DEFAULT = 128;

    // Reset value of the star position limit register
    localparam logic [7:0] STAR_LIMIT_RESET = 8'd82;

    // Characters of interest
    localparam logic [7:0] CHAR_DOLLAR = 8'h24;
    localparam logic [7:0] CHAR_STAR   = 8'h2A;
    localparam logic [7:0] CHAR_LF     = 8'h0A;
    localparam logic [7:0] CHAR_NUL    = 8'h00;
    localparam logic [7:0] CHAR_ZERO   = 8'h30;
    // 'A' less ten, so a nibble of 10..15 maps straight to 'A'..'F'
    localparam logic [7:0] CHAR_HEX_ALPHA_BASE = 8'h37;

    // Sentence kind codes
    localparam logic [2:0] KIND_OTHER = 3'd0;
    localparam logic [2:0] KIND_GGA   = 3'd1;
    localparam logic [2:0] KIND_RMC   = 3'd2;
    localparam logic [2:0] KIND_GLL   = 3'd3;
    localparam logic [2:0] KIND_VTG   = 3'd4;

    localparam int KIND_COUNT = 4;
    localparam int KIND_LEN   = 6;

    // Sentence headers, one row per kind in priority order
    localparam logic [7:0] KIND_TEXT [KIND_COUNT][KIND_LEN] = '{
        '{8'h24, 8'h47, 8'h50, 8'h47, 8'h47, 8'h41},   // $GPGGA
        '{8'h24, 8'h47, 8'h50, 8'h52, 8'h4D, 8'h43},   // $GPRMC
        '{8'h24, 8'h47, 8'h50, 8'h47, 8'h4C, 8'h4C},   // $GPGLL
        '{8'h24, 8'h47, 8'h50, 8'h56, 8'h54, 8'h47}    // $GPVTG
    };

    // One result word
    typedef struct packed {
        logic       sentence_valid;
        logic [2:0] sentence_kind;
        logic [7:0] computed_checksum;
    } nsc_result_t;

    // Uppercase hex character for one nibble
    function automatic logic [7:0] hex_digit(input logic [3:0] nibble);
        logic [7:0] wide;
        wide = {4'h0, nibble};
        if (nibble < 4'd10)
        begin
            return wide + CHAR_ZERO;
        end
        return wide + CHAR_HEX_ALPHA_BASE;
    endfunction

endpackage

@@ src/nsc_line_parser.sv @@
// ----------------------------------------------------------------------------
// NMEA line parser
// Per-line state: position, running XOR, parse phase, check characters and
// header match flags. Flags a line end and forms its result combinationally.
// ----------------------------------------------------------------------------
module nsc_line_parser #(
    parameter int BUF_SIZE = nsc_pkg::BUF_SIZE_DEFAULT
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                byte_accept,
    input  logic [7:0]          rx_byte,
    input  logic [7:0]          star_limit,
    output logic                line_end,
    output nsc_pkg::nsc_result_t result
);

    import nsc_pkg::*;

    localparam int POS_W = $clog2(BUF_SIZE + 1);
    localparam logic [POS_W-1:0] BUF_LIMIT  = POS_W'(BUF_SIZE);
    localparam logic [POS_W-1:0] HEADER_END = POS_W'(KIND_LEN);

    typedef enum logic [2:0] {
        PH_FIRST = 3'd0,
        PH_SCAN  = 3'd1,
        PH_CHK1  = 3'd2,
        PH_CHK2  = 3'd3,
        PH_DONE  = 3'd4
    } phase_t;

    logic [POS_W-1:0]      pos_reg, pos_next;
    logic [7:0]            xor_reg, xor_next;
    phase_t                phase_reg, phase_next;
    logic [15:0]           chk_reg, chk_next;
    logic [KIND_COUNT-1:0] match_reg, match_next;
    logic                  err_reg, err_next;

    logic                  take;
    logic [15:0]           expect_chk;
    logic [2:0]            kind;

    // Line end: newline, or a byte arriving with the buffer full
    assign line_end = (rx_byte == CHAR_LF) || (pos_reg >= BUF_LIMIT);
    assign take     = byte_accept && !line_end;

    // Next state for a stored byte
    always_comb
    begin
        pos_next   = pos_reg;
        xor_next   = xor_reg;
        phase_next = phase_reg;
        chk_next   = chk_reg;
        match_next = match_reg;
        err_next   = err_reg;

        if (take)
        begin
            // header match against each kind
            if (pos_reg < HEADER_END)
            begin
                for (int k = 0; k < KIND_COUNT; k++)
                begin
                    if (rx_byte != KIND_TEXT[k][pos_reg[2:0]])
                    begin
                        match_next[k] = 1'b0;
                    end
                end
            end

            case (phase_reg)
                PH_FIRST:
                begin
                    if (rx_byte == CHAR_DOLLAR)
                    begin
                        phase_next = PH_SCAN;
                    end
                    else
                    begin
                        err_next   = 1'b1;
                        phase_next = PH_DONE;
                    end
                end
                PH_SCAN:
                begin
                    if ((8'(pos_reg) >= star_limit) || (rx_byte == CHAR_NUL))
                    begin
                        err_next   = 1'b1;
                        phase_next = PH_DONE;
                    end
                    else if (rx_byte == CHAR_STAR)
                    begin
                        phase_next = PH_CHK1;
                    end
                    else
                    begin
                        xor_next = xor_reg ^ rx_byte;
                    end
                end
                PH_CHK1:
                begin
                    chk_next   = {rx_byte, 8'h00};
                    phase_next = PH_CHK2;
                end
                PH_CHK2:
                begin
                    chk_next   = {chk_reg[15:8], rx_byte};
                    phase_next = PH_DONE;
                end
                default:
                begin
                    // done: trailing bytes ignored
                end
            endcase

            pos_next = pos_reg + 1'b1;
        end
        else if (byte_accept)
        begin
            // line end: back to a fresh line
            pos_next   = '0;
            xor_next   = '0;
            phase_next = PH_FIRST;
            chk_next   = '0;
            match_next = '1;
            err_next   = 1'b0;
        end
    end

    // Line state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg   <= '0;
            xor_reg   <= '0;
            phase_reg <= PH_FIRST;
            chk_reg   <= '0;
            match_reg <= '1;
            err_reg   <= 1'b0;
        end
        else
        begin
            pos_reg   <= pos_next;
            xor_reg   <= xor_next;
            phase_reg <= phase_next;
            chk_reg   <= chk_next;
            match_reg <= match_next;
            err_reg   <= err_next;
        end
    end

    // Kind: first matching header, only for lines of full header length
    always_comb
    begin
        kind = KIND_OTHER;
        if (pos_reg >= HEADER_END)
        begin
            if (match_reg[0])
            begin
                kind = KIND_GGA;
            end
            else if (match_reg[1])
            begin
                kind = KIND_RMC;
            end
            else if (match_reg[2])
            begin
                kind = KIND_GLL;
            end
            else if (match_reg[3])
            begin
                kind = KIND_VTG;
            end
        end
    end

    // Result of the line held in the state registers
    assign expect_chk = {hex_digit(xor_reg[7:4]), hex_digit(xor_reg[3:0])};

    always_comb
    begin
        result.sentence_valid    = (phase_reg == PH_DONE) && !err_reg
                                   && (chk_reg == expect_chk);
        result.sentence_kind     = kind;
        result.computed_checksum = xor_reg;
    end

endmodule

@@ src/nmea_sentence_checker_core.sv @@
// ----------------------------------------------------------------------------
// NMEA sentence checker core
// Frames a byte stream into lines and reports framing, checksum and kind
// of each finished line.
// ----------------------------------------------------------------------------
// A result word is shown in the cycle after the byte ending its line is accepted.
// Throughput: one byte per cycle; the line state takes each byte in a single
// pass, and the input is held off only while a result word is stalled.
// Reset: asynchronous, active low; clears line state, the result valid flag
// and sets the star position limit to 82. No clearing pass is needed.
// ----------------------------------------------------------------------------
module nmea_sentence_checker_core #(
    parameter int BUF_SIZE = nsc_pkg::BUF_SIZE_DEFAULT
) (
    input  logic       clk,
    input  logic       rst_n,
    // byte input
    input  logic       rx_valid,
    output logic       rx_stall,
    input  logic [7:0] rx_byte,
    // limit register write
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic [7:0] cfg_data,
    // result output
    output logic       res_valid,
    input  logic       res_stall,
    output logic       sentence_valid,
    output logic [2:0] sentence_kind,
    output logic [7:0] computed_checksum
);

    import nsc_pkg::*;

    logic [7:0]  limit_reg;
    logic        byte_accept;
    logic        line_end;
    nsc_result_t line_result;
    nsc_result_t res_reg;
    logic        res_valid_reg, res_valid_next;

    // Configuration write, always ready
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limit_reg <= STAR_LIMIT_RESET;
        end
        else if (cfg_valid)
        begin
            limit_reg <= cfg_data;
        end
    end

    // Input handshake: blocked only while a result word is held up
    assign rx_stall    = res_valid_reg && res_stall;
    assign byte_accept = rx_valid && !rx_stall;

    nsc_line_parser #(
        .BUF_SIZE (BUF_SIZE)
    ) u_parser (
        .clk         (clk),
        .rst_n       (rst_n),
        .byte_accept (byte_accept),
        .rx_byte     (rx_byte),
        .star_limit  (limit_reg),
        .line_end    (line_end),
        .result      (line_result)
    );

    // Result register
    always_comb
    begin
        res_valid_next = res_valid_reg && res_stall;
        if (byte_accept && line_end)
        begin
            res_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else
        begin
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (byte_accept && line_end)
        begin
            res_reg <= line_result;
        end
    end

    assign res_valid         = res_valid_reg;
    assign sentence_valid    = res_reg.sentence_valid;
    assign sentence_kind     = res_reg.sentence_kind;
    assign computed_checksum = res_reg.computed_checksum;

endmodule

@@ src/nsc_checker.sv @@
// ----------------------------------------------------------------------------
// NMEA sentence checker port checks
// Concurrent checks on the core's ports, attached by bind.
// ----------------------------------------------------------------------------
module nsc_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       rx_valid,
    input logic       rx_stall,
    input logic [7:0] rx_byte,
    input logic       res_valid,
    input logic       res_stall,
    input logic       sentence_valid,
    input logic [2:0] sentence_kind,
    input logic [7:0] computed_checksum
);

    import nsc_pkg::*;

    // A held-up result word keeps its valid and contents
    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_stall |=> res_valid
            && $stable(sentence_valid) && $stable(sentence_kind)
            && $stable(computed_checksum))
        else $error("stalled result word changed");

    // An accepted newline gives a result word in the next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        rx_valid && !rx_stall && (rx_byte == CHAR_LF) |=> res_valid)
        else $error("newline gave no result word");

    // A new result word only follows an accepted byte
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(res_valid) |-> $past(rx_valid && !rx_stall))
        else $error("result word without an accepted byte");

    // Input never blocked while no result word is waiting
    assert property (@(posedge clk) disable iff (!rst_n)
        !res_valid |-> !rx_stall)
        else $error("input stalled with result register empty");

endmodule

bind nmea_sentence_checker_core nsc_checker u_nsc_checker (
    .clk               (clk),
    .rst_n             (rst_n),
    .rx_valid          (rx_valid),
    .rx_stall          (rx_stall),
    .rx_byte           (rx_byte),
    .res_valid         (res_valid),
    .res_stall         (res_stall),
    .sentence_valid    (sentence_valid),
    .sentence_kind     (sentence_kind),
    .computed_checksum (computed_checksum)
);

@@ verif/testbench.sv @@
// ----------------------------------------------------------------------------
// NMEA sentence checker testbench
// Streams sentences, broken lines and noise bytes into the checker and
// compares every result word with a line-tracking predictor kept in step
// with each accepted byte. Both channels idle and stall at random, the
// result side holds off once for a long stretch, and the star position
// limit is rewritten between lines and once mid-line, including its extremes.
// ----------------------------------------------------------------------------
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import nsc_pkg::*;

    localparam int         LINE_BYTES      = BUF_SIZE_DEFAULT;
    localparam logic [7:0] LIMIT_AT_RESET  = 8'd82;
    localparam logic [7:0] BYTE_CR         = 8'h0D;
    localparam int         SETTLE_CYCLES   = 4;
    localparam int         RANDOM_BYTES    = 1000;
    localparam int         RANDOM_LINES    = 30;

    typedef enum logic [2:0] {
        SEEK_DOLLAR,
        IN_BODY,
        CHECK_HI,
        CHECK_LO,
        LINE_DONE
    } scan_phase_t;

    typedef enum {SUM_GOOD, SUM_WRONG, SUM_LOWER, SUM_NONE} sum_style_t;
    typedef enum {TAIL_NONE, TAIL_LF, TAIL_CRLF, TAIL_JUNK} tail_t;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       rx_valid = 1'b0;
    logic       rx_stall;
    logic [7:0] rx_byte = 8'h00;
    logic       cfg_valid = 1'b0;
    logic       cfg_ready;
    logic [7:0] cfg_data = 8'h00;
    logic       res_valid;
    logic       res_stall = 1'b0;
    logic       sentence_valid;
    logic [2:0] sentence_kind;
    logic [7:0] computed_checksum;

    // predictor state, one line at a time
    logic [7:0]  star_limit;
    logic [7:0]  line_len;
    logic [7:0]  line_xor;
    scan_phase_t scan_phase;
    logic [15:0] check_chars;
    logic [3:0]  header_hits;
    logic        line_bad;

    nsc_result_t sentences_due[$];
    logic [7:0]  line_buf[$];

    int  wrong_words = 0;
    int  bytes_sent = 0;
    int  sink_hold = 0;
    bit  sender_quick = 1'b0;
    bit  sink_quick = 1'b0;

    nmea_sentence_checker_core #(
        .BUF_SIZE(LINE_BYTES)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .rx_valid(rx_valid),
        .rx_stall(rx_stall),
        .rx_byte(rx_byte),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_data(cfg_data),
        .res_valid(res_valid),
        .res_stall(res_stall),
        .sentence_valid(sentence_valid),
        .sentence_kind(sentence_kind),
        .computed_checksum(computed_checksum)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    function automatic logic [7:0] hex_char(input logic [3:0] nib);
        if (nib < 4'd10)
        begin
            return CHAR_ZERO + nib;
        end
        return "A" + nib - 8'd10;
    endfunction

    task automatic clear_line();
        line_len    = 8'd0;
        line_xor    = 8'h00;
        scan_phase  = SEEK_DOLLAR;
        check_chars = 16'h0000;
        header_hits = 4'hF;
        line_bad    = 1'b0;
    endtask

    // Fold one accepted byte into the line; a line end queues a result word
    task automatic track_line_byte(input logic [7:0] b);
        nsc_result_t word;
        logic [47:0] hdr;
        logic [15:0] want;
        int          k;
        int          p;
        if (b != CHAR_LF && line_len < LINE_BYTES)
        begin
            p = int'(line_len);
            if (p < 6)
            begin
                for (k = 0; k < 4; k++)
                begin
                    case (k)
                        0: hdr = "$GPGGA";
                        1: hdr = "$GPRMC";
                        2: hdr = "$GPGLL";
                        default: hdr = "$GPVTG";
                    endcase
                    if (b != hdr[47 - 8 * p -: 8])
                    begin
                        header_hits[k] = 1'b0;
                    end
                end
            end
            case (scan_phase)
                SEEK_DOLLAR:
                begin
                    if (b == CHAR_DOLLAR)
                    begin
                        scan_phase = IN_BODY;
                    end
                    else
                    begin
                        line_bad   = 1'b1;
                        scan_phase = LINE_DONE;
                    end
                end
                IN_BODY:
                begin
                    if (line_len >= star_limit || b == CHAR_NUL)
                    begin
                        line_bad   = 1'b1;
                        scan_phase = LINE_DONE;
                    end
                    else if (b == CHAR_STAR)
                    begin
                        scan_phase = CHECK_HI;
                    end
                    else
                    begin
                        line_xor = line_xor ^ b;
                    end
                end
                CHECK_HI:
                begin
                    check_chars = {b, 8'h00};
                    scan_phase  = CHECK_LO;
                end
                CHECK_LO:
                begin
                    check_chars[7:0] = b;
                    scan_phase       = LINE_DONE;
                end
                default:
                begin
                end
            endcase
            line_len = line_len + 8'd1;
        end
        else
        begin
            // line end: judge and report, the ending byte is not stored
            want = {hex_char(line_xor[7:4]), hex_char(line_xor[3:0])};
            word.sentence_valid    = (scan_phase == LINE_DONE) && !line_bad
                                     && (check_chars == want);
            word.sentence_kind     = KIND_OTHER;
            word.computed_checksum = line_xor;
            if (line_len >= 8'd6)
            begin
                if (header_hits[0])
                    word.sentence_kind = KIND_GGA;
                else if (header_hits[1])
                    word.sentence_kind = KIND_RMC;
                else if (header_hits[2])
                    word.sentence_kind = KIND_GLL;
                else if (header_hits[3])
                    word.sentence_kind = KIND_VTG;
            end
            sentences_due.push_back(word);
            clear_line();
        end
    endtask

    // ------------------------------------------------------------------
    // Result side: random stalls plus an optional long hold-off
    // ------------------------------------------------------------------
    initial
    begin : result_sink
        int n;
        @(posedge rst_n);
        forever
        begin
            n = sink_quick ? 0 : $urandom_range(0, 18);
            if (sink_hold > 0)
            begin
                n         = sink_hold;
                sink_hold = 0;
            end
            if (n > 0)
            begin
                res_stall <= 1'b1;
                repeat (n) @(posedge clk);
            end
            res_stall <= 1'b0;
            do @(posedge clk); while (!res_valid);
        end
    end

    // Compare each accepted result word with the oldest expectation
    always @(posedge clk)
    begin : sentence_check
        nsc_result_t want;
        if (rst_n && res_valid && !res_stall)
        begin
            if (sentences_due.size() == 0)
            begin
                if (wrong_words < 10)
                    $display("unexpected word: valid %0b kind %0d sum %02h",
                             sentence_valid, sentence_kind, computed_checksum);
                wrong_words++;
            end
            else
            begin
                want = sentences_due.pop_front();
                if (sentence_valid !== want.sentence_valid
                    || sentence_kind !== want.sentence_kind
                    || computed_checksum !== want.computed_checksum)
                begin
                    if (wrong_words < 10)
                        $display({"word mismatch: expected valid %0b kind %0d sum %02h,",
                                  " got valid %0b kind %0d sum %02h"},
                                 want.sentence_valid, want.sentence_kind,
                                 want.computed_checksum, sentence_valid,
                                 sentence_kind, computed_checksum);
                    wrong_words++;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Byte side
    // ------------------------------------------------------------------

    // Offer one byte after a random gap; valid stays up for a following byte
    task automatic send_byte(input logic [7:0] b);
        int gap;
        gap = sender_quick ? 0 : $urandom_range(0, 18);
        if (gap > 0)
        begin
            rx_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        rx_valid <= 1'b1;
        rx_byte  <= b;
        do @(posedge clk); while (rx_stall);
        track_line_byte(b);
        bytes_sent++;
    endtask

    // Stop offering and let every pending word come out
    task automatic wait_drained();
        rx_valid <= 1'b0;
        while (sentences_due.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_limit(input logic [7:0] v);
        wait_drained();
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        star_limit = v;
    endtask

    task automatic put_byte(input logic [7:0] b);
        line_buf.push_back(b);
    endtask

    task automatic put_text(input string s);
        int i;
        for (i = 0; i < s.len(); i++)
            line_buf.push_back(s[i]);
    endtask

    // Append '*' and two check characters over everything after the first byte
    task automatic put_checksum(input sum_style_t style);
        logic [7:0] x;
        logic [7:0] flip;
        logic [7:0] hi;
        logic [7:0] lo;
        int         i;
        x = 8'h00;
        for (i = 1; i < line_buf.size(); i++)
            x = x ^ line_buf[i];
        if (style == SUM_WRONG)
        begin
            flip = 8'($urandom_range(1, 255));
            x    = x ^ flip;
        end
        hi = hex_char(x[7:4]);
        lo = hex_char(x[3:0]);
        if (style == SUM_LOWER)
        begin
            if (hi > "9")
                hi = hi + 8'h20;
            if (lo > "9")
                lo = lo + 8'h20;
        end
        line_buf.push_back(CHAR_STAR);
        line_buf.push_back(hi);
        line_buf.push_back(lo);
    endtask

    task automatic put_tail(input tail_t t);
        case (t)
            TAIL_LF:
                put_byte(CHAR_LF);
            TAIL_CRLF:
            begin
                put_byte(BYTE_CR);
                put_byte(CHAR_LF);
            end
            TAIL_JUNK:
            begin
                repeat ($urandom_range(1, 3)) put_byte(8'("A" + $urandom_range(0, 25)));
                put_byte(BYTE_CR);
                put_byte(CHAR_LF);
            end
            default:
            begin
            end
        endcase
    endtask

    task automatic flush_line();
        int i;
        for (i = 0; i < line_buf.size(); i++)
            send_byte(line_buf[i]);
        line_buf.delete();
    endtask

    task automatic send_sentence(input string body, input sum_style_t style, input tail_t t);
        put_byte(CHAR_DOLLAR);
        put_text(body);
        if (style != SUM_NONE)
            put_checksum(style);
        put_tail(t);
        flush_line();
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    task automatic test_directed();
        int n;
        // each kind, then near misses and short lines
        send_sentence("GPGGA,123519,4807.038,N", SUM_GOOD, TAIL_CRLF);
        send_sentence("GPRMC,225446,A", SUM_GOOD, TAIL_CRLF);
        send_sentence("GPGLL,4916.45,N", SUM_GOOD, TAIL_LF);
        send_sentence("GPVTG", SUM_GOOD, TAIL_LF);
        send_sentence("GPGGB,1", SUM_GOOD, TAIL_LF);
        send_sentence("GNRMC,1", SUM_GOOD, TAIL_CRLF);
        send_sentence("G", SUM_GOOD, TAIL_LF);
        send_sentence("GPGG", SUM_NONE, TAIL_LF);
        send_sentence("", SUM_GOOD, TAIL_LF);
        send_sentence("", SUM_NONE, TAIL_LF);
        // checksum faults and missing check characters
        send_sentence("GPGGA,9", SUM_WRONG, TAIL_CRLF);
        send_sentence("GPRMC,Z", SUM_LOWER, TAIL_LF);
        send_sentence("GPGLL,77", SUM_NONE, TAIL_LF);
        send_sentence("GPVTG*", SUM_NONE, TAIL_LF);
        send_sentence("GPVTG*4", SUM_NONE, TAIL_LF);
        // bytes after the check characters are ignored
        send_sentence("GPGGA,1", SUM_GOOD, TAIL_JUNK);
        // no leading dollar, then a blank line
        put_text("GPGGA,1*33");
        put_tail(TAIL_CRLF);
        flush_line();
        put_tail(TAIL_LF);
        flush_line();
        // zero byte ahead of the star
        put_text("$GP");
        put_byte(CHAR_NUL);
        put_text("A*00");
        put_tail(TAIL_LF);
        flush_line();
        // top-bit bytes in the body
        put_byte(CHAR_DOLLAR);
        put_byte(8'hFF);
        put_byte(8'h80);
        put_byte(8'h55);
        put_checksum(SUM_GOOD);
        put_tail(TAIL_LF);
        flush_line();
        // star one below the reset limit, then on it
        for (n = 80; n <= 81; n++)
        begin
            put_byte(CHAR_DOLLAR);
            repeat (n) put_byte("7");
            put_checksum(SUM_GOOD);
            put_tail(TAIL_CRLF);
            flush_line();
        end
        wait_drained();
    endtask

    task automatic test_limit_register();
        // lowest limit: only a star straight after the dollar passes
        write_limit(8'd2);
        send_sentence("", SUM_GOOD, TAIL_LF);
        send_sentence("A", SUM_GOOD, TAIL_LF);
        // highest limit: star deep in the line, then full buffers
        write_limit(8'd255);
        put_byte(CHAR_DOLLAR);
        repeat (120) put_byte(",");
        put_checksum(SUM_GOOD);
        put_tail(TAIL_CRLF);
        flush_line();
        // buffer full; the next byte ends the line and is dropped
        put_byte(CHAR_DOLLAR);
        repeat (124) put_byte("5");
        put_checksum(SUM_GOOD);
        put_byte("Q");
        put_tail(TAIL_LF);
        flush_line();
        put_byte(CHAR_DOLLAR);
        repeat (127) put_byte("1");
        put_tail(TAIL_LF);
        flush_line();
        // limit lowered part way through a line
        write_limit(LIMIT_AT_RESET);
        put_text("$GPGGA,12345");
        flush_line();
        write_limit(8'd8);
        put_text(",678*00");
        put_tail(TAIL_CRLF);
        flush_line();
        write_limit(LIMIT_AT_RESET);
    endtask

    // Result side holds off while bytes keep coming, then the sender drains
    task automatic test_result_backpressure();
        int i;
        sink_hold    = 400;
        sender_quick = 1'b1;
        for (i = 0; i < 12; i++)
            send_sentence("GPRMC,1", SUM_GOOD, TAIL_LF);
        sender_quick = 1'b0;
        wait_drained();
    endtask

    task automatic test_random_traffic();
        int         first;
        int         lines;
        int         form;
        int         r;
        logic [7:0] c;
        logic [7:0] v;
        tail_t      t;
        first = bytes_sent;
        lines = 0;
        while (bytes_sent - first < RANDOM_BYTES || lines < RANDOM_LINES)
        begin
            if (lines % 10 == 0)
            begin
                case ($urandom_range(0, 4))
                    0: v = 8'd2;
                    1: v = 8'd255;
                    2: v = LIMIT_AT_RESET;
                    3: v = 8'($urandom_range(2, 255));
                    default: v = 8'($urandom_range(20, 90));
                endcase
                write_limit(v);
            end
            sender_quick = ($urandom_range(0, 4) == 0);
            sink_quick   = ($urandom_range(0, 4) == 0);
            form = $urandom_range(0, 99);
            case ($urandom_range(0, 3))
                0: t = TAIL_LF;
                3: t = TAIL_JUNK;
                default: t = TAIL_CRLF;
            endcase
            if (form < 92)
            begin
                // sentence: header, then a body of field-like characters
                put_byte(CHAR_DOLLAR);
                case ($urandom_range(0, 5))
                    0: put_text("GPGGA");
                    1: put_text("GPRMC");
                    2: put_text("GPGLL");
                    3: put_text("GPVTG");
                    4: repeat (5) put_byte(8'("A" + $urandom_range(0, 25)));
                    default:
                    begin
                        put_text("GPGGA");
                        line_buf[$urandom_range(1, 5)] = 8'("A" + $urandom_range(0, 25));
                    end
                endcase
                repeat (($urandom_range(0, 9) == 0) ? $urandom_range(40, 125)
                                                    : $urandom_range(0, 30))
                begin
                    r = $urandom_range(0, 19);
                    if (r == 0)
                        c = 8'($urandom_range(128, 255));
                    else if (r < 7)
                        c = 8'(CHAR_ZERO + $urandom_range(0, 9));
                    else if (r < 10)
                        c = ",";
                    else
                    begin
                        c = 8'($urandom_range(32, 126));
                        if (c == CHAR_STAR)
                            c = ".";
                    end
                    put_byte(c);
                end
                if (form < 70)
                    put_checksum(SUM_GOOD);
                else if (form < 74)
                    put_checksum(SUM_WRONG);
                else if (form < 77)
                    put_checksum(SUM_LOWER);
                else if (form < 80)
                begin
                    // check characters cut short
                    put_checksum(SUM_GOOD);
                    repeat ($urandom_range(1, 2)) line_buf.delete(line_buf.size() - 1);
                end
                else if (form < 83)
                begin
                    // no star at all
                end
                else if (form < 86)
                begin
                    put_checksum(SUM_GOOD);
                    line_buf[$urandom_range(1, line_buf.size() - 4)] = CHAR_NUL;
                end
                else if (form < 89)
                begin
                    put_checksum(SUM_GOOD);
                    c = 8'($urandom_range(0, 255));
                    if (c == CHAR_DOLLAR)
                        c = "X";
                    line_buf[0] = c;
                end
                else
                begin
                    // runs on into the next line
                    put_checksum(SUM_GOOD);
                    t = TAIL_NONE;
                end
            end
            else
            begin
                // raw noise over the whole byte range
                repeat ($urandom_range(1, 40)) put_byte(8'($urandom_range(0, 255)));
                t = ($urandom_range(0, 1) == 0) ? TAIL_LF : TAIL_NONE;
            end
            put_tail(t);
            flush_line();
            lines++;
        end
        sender_quick = 1'b0;
        sink_quick   = 1'b0;
    endtask

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------
    initial
    begin : run_tests
        star_limit = LIMIT_AT_RESET;
        clear_line();
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_limit_register();
        test_result_backpressure();
        test_random_traffic();
        wait_drained();
        if (wrong_words == 0 && sentences_due.size() == 0)
            $display("testbench OK");
        else
            $display("testbench NOT OK");
        $finish;
    end

    // Hang guard
    initial
    begin : watchdog
        #4000000;
        $display("testbench NOT OK");
        $finish;
    end

endmodule
